// File: design/gdsp_pkg.sv
`timescale 1ns / 1ps
package gdsp_pkg;
  localparam logic [15:0] MAX_LEN_RESET = 16'd65532;

  localparam logic [15:0] T_ENDLIB   = 16'h0400;
  localparam logic [15:0] T_BGNSTR   = 16'h0502;
  localparam logic [15:0] T_ENDSTR   = 16'h0700;
  localparam logic [15:0] T_BOUNDARY = 16'h0800;
  localparam logic [15:0] T_PATH     = 16'h0900;
  localparam logic [15:0] T_SREF     = 16'h0A00;
  localparam logic [15:0] T_AREF     = 16'h0B00;
  localparam logic [15:0] T_TEXT     = 16'h0C00;
  localparam logic [15:0] T_LAYER    = 16'h0D02;
  localparam logic [15:0] T_DATATYPE = 16'h0E02;
  localparam logic [15:0] T_WIDTH    = 16'h0F03;
  localparam logic [15:0] T_XY       = 16'h1003;
  localparam logic [15:0] T_ENDEL    = 16'h1100;
  localparam logic [15:0] T_COLROW   = 16'h1302;
  localparam logic [15:0] T_STRANS   = 16'h1A01;
  localparam logic [15:0] T_BOX      = 16'h2D00;

  localparam logic [2:0] EV_POINT  = 3'd0;
  localparam logic [2:0] EV_ENDEL  = 3'd1;
  localparam logic [2:0] EV_BGNSTR = 3'd2;
  localparam logic [2:0] EV_ENDSTR = 3'd3;
  localparam logic [2:0] EV_ENDLIB = 3'd4;
  localparam logic [2:0] EV_RESYNC = 3'd5;

  localparam logic [2:0] K_BOUNDARY = 3'd0;
  localparam logic [2:0] K_PATH     = 3'd1;
  localparam logic [2:0] K_SREF     = 3'd2;
  localparam logic [2:0] K_AREF     = 3'd3;
  localparam logic [2:0] K_TEXT     = 3'd4;
  localparam logic [2:0] K_BOX      = 3'd5;
  localparam logic [2:0] K_TOP      = 3'd7;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [2:0]  element_kind;
    logic [15:0] layer_number;
    logic [15:0] data_type;
    logic [31:0] path_width;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [12:0] point_index;
    logic [15:0] array_columns;
    logic [15:0] array_rows;
    logic        reflected;
  } result_t;
endpackage

// File: design/gdsp_front.sv
`timescale 1ns / 1ps
module gdsp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_valid,
  input  logic [7:0]           byte_data,
  input  logic [15:0]          max_len,
  output logic                 res_valid,
  output gdsp_pkg::result_t    res
);
  logic [23:0] hdr_r;
  logic [1:0]  hcnt_r;
  logic [15:0] prem_r;
  logic [15:0] type_r;
  logic [2:0]  ctx_r;
  logic        sopen_r;
  logic        skip_r;
  logic [63:0] fs_r;
  logic [15:0] layer_r, dtype_r;
  logic [31:0] width_r, colrow_r;
  logic        refl_r;
  logic [63:0] origin_r;
  logic [12:0] pcnt_r;
  logic [15:0] use_r;

  logic [15:0] len, typ, ds, use_v;
  logic [63:0] fs_nxt;
  logic [31:0] ox, oy;

  assign len    = {hdr_r[23:8]};
  assign typ    = {hdr_r[7:0], byte_data};
  assign ds     = len - 16'd4;
  assign fs_nxt = {fs_r[55:0], byte_data};

  // bytes of the record that feed a field; zero at top level and for ENDEL
  always_comb begin
    use_v = '0;
    case (typ)
      gdsp_pkg::T_LAYER:
        if ((ctx_r == gdsp_pkg::K_BOUNDARY || ctx_r == gdsp_pkg::K_PATH ||
             ctx_r == gdsp_pkg::K_TEXT || ctx_r == gdsp_pkg::K_BOX) && ds >= 16'd2)
          use_v = 16'd2;
      gdsp_pkg::T_DATATYPE:
        if (ctx_r == gdsp_pkg::K_BOUNDARY && ds >= 16'd2) use_v = 16'd2;
      gdsp_pkg::T_WIDTH:
        if (ctx_r == gdsp_pkg::K_PATH && ds >= 16'd4) use_v = 16'd4;
      gdsp_pkg::T_STRANS:
        if (ctx_r == gdsp_pkg::K_SREF && ds >= 16'd2) use_v = 16'd2;
      gdsp_pkg::T_COLROW:
        if (ctx_r == gdsp_pkg::K_AREF && ds >= 16'd4) use_v = 16'd4;
      gdsp_pkg::T_XY: begin
        if (ctx_r == gdsp_pkg::K_BOUNDARY || ctx_r == gdsp_pkg::K_PATH ||
            ctx_r == gdsp_pkg::K_BOX)
          use_v = {ds[15:3], 3'b000};
        else if (ctx_r == gdsp_pkg::K_SREF || ctx_r == gdsp_pkg::K_TEXT)
          use_v = (ds >= 16'd8) ? 16'd8 : 16'd0;
        else if (ctx_r == gdsp_pkg::K_AREF)
          use_v = (ds >= 16'd24) ? 16'd24 : 16'd0;
      end
      default: use_v = '0;
    endcase
  end

  assign ox = (pcnt_r == '0) ? 32'd0 : origin_r[63:32];
  assign oy = (pcnt_r == '0) ? 32'd0 : origin_r[31:0];

  always_ff @(posedge clk) begin
    gdsp_pkg::result_t res_nxt;
    logic              res_valid_nxt;
    res_nxt       = '0;
    res_valid_nxt = 1'b0;
    if (!rst_n) begin
      hcnt_r <= '0; prem_r <= '0; type_r <= '0; ctx_r <= gdsp_pkg::K_TOP;
      sopen_r <= 1'b0; skip_r <= 1'b0; layer_r <= '0; dtype_r <= '0;
      width_r <= '0; colrow_r <= '0; refl_r <= 1'b0; origin_r <= '0;
      pcnt_r <= '0; use_r <= '0; res_valid <= 1'b0; hdr_r <= '0; fs_r <= '0;
    end else begin
      if (byte_valid) begin
        if (skip_r) begin
          skip_r <= 1'b0;
        end else if (prem_r != '0) begin
          prem_r <= prem_r - 16'd1;
          if (use_r != '0) begin
            use_r <= use_r - 16'd1;
            fs_r  <= fs_nxt;
            if (type_r == gdsp_pkg::T_XY) begin
              if (use_r[2:0] == 3'd1) begin
                pcnt_r <= pcnt_r + 13'd1;
                res_valid_nxt = 1'b1;
                res_nxt.event_res     = gdsp_pkg::EV_POINT;
                res_nxt.element_kind  = ctx_r;
                res_nxt.layer_number  = layer_r;
                res_nxt.data_type     = dtype_r;
                res_nxt.path_width    = width_r;
                res_nxt.point_index   = pcnt_r;
                res_nxt.array_columns = colrow_r[31:16];
                res_nxt.array_rows    = colrow_r[15:0];
                res_nxt.reflected     = refl_r;
                if (ctx_r == gdsp_pkg::K_AREF) begin
                  if (pcnt_r == '0) origin_r <= fs_nxt;
                  res_nxt.coord_x = fs_nxt[63:32] - ox;
                  res_nxt.coord_y = fs_nxt[31:0] - oy;
                end else begin
                  res_nxt.coord_x = fs_nxt[63:32];
                  res_nxt.coord_y = fs_nxt[31:0];
                end
              end
            end else if (use_r == 16'd1) begin
              case (type_r)
                gdsp_pkg::T_LAYER:    layer_r  <= fs_nxt[15:0];
                gdsp_pkg::T_DATATYPE: dtype_r  <= fs_nxt[15:0];
                gdsp_pkg::T_WIDTH:    width_r  <= fs_nxt[31:0];
                gdsp_pkg::T_COLROW:   colrow_r <= fs_nxt[31:0];
                gdsp_pkg::T_STRANS:   refl_r   <= fs_nxt[15];
                default: ;
              endcase
            end
          end
        end else if (hcnt_r != 2'd3) begin
          hdr_r  <= {hdr_r[15:0], byte_data};
          hcnt_r <= hcnt_r + 2'd1;
        end else begin
          hcnt_r <= '0;
          hdr_r  <= {hdr_r[15:0], byte_data};
          if (len < 16'd4 || len > max_len) begin
            skip_r <= 1'b1;
            res_valid_nxt = 1'b1;
            res_nxt.event_res = gdsp_pkg::EV_RESYNC;
          end else begin
            prem_r <= ds; type_r <= typ; use_r <= use_v; pcnt_r <= '0; fs_r <= '0;
            if (ctx_r == gdsp_pkg::K_TOP) begin
              case (typ)
                gdsp_pkg::T_BGNSTR: begin
                  sopen_r <= 1'b1; res_valid_nxt = 1'b1;
                  res_nxt.event_res = gdsp_pkg::EV_BGNSTR;
                end
                gdsp_pkg::T_ENDSTR:
                  if (sopen_r) begin
                    sopen_r <= 1'b0; res_valid_nxt = 1'b1;
                    res_nxt.event_res = gdsp_pkg::EV_ENDSTR;
                  end
                gdsp_pkg::T_ENDLIB: begin
                  res_valid_nxt = 1'b1; res_nxt.event_res = gdsp_pkg::EV_ENDLIB;
                end
                gdsp_pkg::T_BOUNDARY, gdsp_pkg::T_PATH, gdsp_pkg::T_SREF,
                gdsp_pkg::T_AREF, gdsp_pkg::T_TEXT, gdsp_pkg::T_BOX:
                  if (sopen_r) begin
                    layer_r <= '0; dtype_r <= '0; width_r <= '0;
                    colrow_r <= '0; refl_r <= 1'b0; origin_r <= '0;
                    case (typ)
                      gdsp_pkg::T_BOUNDARY: ctx_r <= gdsp_pkg::K_BOUNDARY;
                      gdsp_pkg::T_PATH:     ctx_r <= gdsp_pkg::K_PATH;
                      gdsp_pkg::T_SREF:     ctx_r <= gdsp_pkg::K_SREF;
                      gdsp_pkg::T_AREF:     ctx_r <= gdsp_pkg::K_AREF;
                      gdsp_pkg::T_TEXT:     ctx_r <= gdsp_pkg::K_TEXT;
                      default:              ctx_r <= gdsp_pkg::K_BOX;
                    endcase
                  end
                default: ;
              endcase
            end else if (typ == gdsp_pkg::T_ENDEL) begin
              ctx_r <= gdsp_pkg::K_TOP;
              res_valid_nxt = 1'b1;
              res_nxt.event_res     = gdsp_pkg::EV_ENDEL;
              res_nxt.element_kind  = ctx_r;
              res_nxt.layer_number  = layer_r;
              res_nxt.data_type     = dtype_r;
              res_nxt.path_width    = width_r;
              res_nxt.array_columns = colrow_r[31:16];
              res_nxt.array_rows    = colrow_r[15:0];
              res_nxt.reflected     = refl_r;
            end
          end
        end
      end
      res_valid <= res_valid_nxt;
      res       <= res_nxt;
    end
  end
endmodule

// File: design/gdsp_queue.sv
`timescale 1ns / 1ps
module gdsp_queue #(
  parameter int DEPTH = gdsp_pkg::QDEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  gdsp_pkg::result_t wr_data,
  output logic              almost_full,
  output logic              rd_valid,
  output gdsp_pkg::result_t rd_data,
  input  logic              rd_en
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  gdsp_pkg::result_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign rd_valid    = cnt_r != '0;
  assign rd_data     = mem[rp_r];
  // two slots kept for the two bytes in flight through the front
  assign almost_full = cnt_r >= (AW+1)'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule

// File: design/gdsii_record_stream_parser.sv
`timescale 1ns / 1ps
// GDSII record stream parser.
// Input channel (in_valid / in_stall / in_data_byte): one stream byte per
// transfer, one transfer per cycle sustained while in_stall is low.
// Result channel (out_valid / out_stall / out_*): zero or one result per byte:
// XY points, element end, structure begin/end, library end and resync events.
// A result passes through the front register, then the queue, before it is
// visible at the outputs.
// Throughput: one byte per cycle while in_stall is low; the front decodes a
// byte with a shift and a compare, independent of the record length.
// The front writes results into a four-entry queue; the back side drains it.
// When the receiver stalls, results pile up in the queue; in_stall rises once
// only two free slots remain, covering the byte held in the front register.
// Reset (rst_n low, synchronous) clears the parser context, held fields, the
// queue and restores max_record_length to 65532.
// Config: one APB register at address 0, max_record_length (16 bits).
module gdsii_record_stream_parser #(
  parameter int QUEUE_DEPTH = gdsp_pkg::QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [2:0]  out_element_kind,
  output logic signed [15:0] out_layer_number,
  output logic signed [15:0] out_data_type,
  output logic signed [31:0] out_path_width,
  output logic signed [31:0] out_coord_x,
  output logic signed [31:0] out_coord_y,
  output logic [12:0] out_point_index,
  output logic [15:0] out_array_columns,
  output logic [15:0] out_array_rows,
  output logic        out_reflected,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [15:0] max_len_r;
  logic        acc;
  logic        fr_valid;
  gdsp_pkg::result_t fr_res, q_res;
  logic        q_afull;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr ? 32'd0 : {16'd0, max_len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= gdsp_pkg::MAX_LEN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr) begin
      max_len_r <= cfg_pwdata[15:0];
    end
  end

  assign in_stall = q_afull;
  assign acc      = in_valid && !in_stall;

  gdsp_front u_front (
    .clk(clk), .rst_n(rst_n), .byte_valid(acc), .byte_data(in_data_byte),
    .max_len(max_len_r), .res_valid(fr_valid), .res(fr_res)
  );

  gdsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(fr_valid), .wr_data(fr_res),
    .almost_full(q_afull), .rd_valid(out_valid), .rd_data(q_res),
    .rd_en(out_valid && !out_stall)
  );

  assign out_event_res     = q_res.event_res;
  assign out_element_kind  = q_res.element_kind;
  assign out_layer_number  = q_res.layer_number;
  assign out_data_type     = q_res.data_type;
  assign out_path_width    = q_res.path_width;
  assign out_coord_x       = q_res.coord_x;
  assign out_coord_y       = q_res.coord_y;
  assign out_point_index   = q_res.point_index;
  assign out_array_columns = q_res.array_columns;
  assign out_array_rows    = q_res.array_rows;
  assign out_reflected     = q_res.reflected;

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_afull |-> !acc) else $error("byte taken with queue near full");
  a_resync_gap: assert property (@(posedge clk) disable iff (!rst_n)
    fr_valid && fr_res.event_res == gdsp_pkg::EV_RESYNC |-> fr_res.coord_x == '0)
    else $error("resync result carries data");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
endmodule

// File: test/tb_gdsii_record_stream_parser.sv
`timescale 1ns / 1ps
// Stream parser bench: drives GDSII byte streams, predicts results in a scoreboard.
module tb_gdsii_record_stream_parser;

  // Predictor and store of expected results.
  class gds_scoreboard;
    logic [15:0] max_len;
    logic [31:0] hdr;
    int unsigned hdr_cnt;
    logic [15:0] pay_left, rec_type, use_left;
    logic [2:0]  ctx;
    bit          str_open, skip_next;
    logic [63:0] fshift, origin;
    logic [15:0] lay, dt;
    logic [31:0] wid, colrow;
    bit          refl;
    logic [12:0] pcount;
    gdsp_pkg::result_t pending[$];
    int          errors;

    function new();
      max_len = gdsp_pkg::MAX_LEN_RESET; hdr = '0; hdr_cnt = 0; pay_left = '0;
      rec_type = '0; use_left = '0; ctx = gdsp_pkg::K_TOP; str_open = 0;
      skip_next = 0; fshift = '0; origin = '0; lay = '0; dt = '0; wid = '0;
      colrow = '0; refl = 0; pcount = '0;
      errors = 0;
    endfunction

    function void push_event(logic [2:0] ev);
      gdsp_pkg::result_t r;
      r = '0;
      r.event_res = ev;
      pending.push_back(r);
    endfunction

    function void push_held(logic [2:0] ev, logic [2:0] k, logic [31:0] x,
                            logic [31:0] y, logic [12:0] idx);
      gdsp_pkg::result_t r;
      r.event_res = ev; r.element_kind = k; r.layer_number = lay;
      r.data_type = dt; r.path_width = wid; r.coord_x = x; r.coord_y = y;
      r.point_index = idx; r.array_columns = colrow[31:16];
      r.array_rows = colrow[15:0]; r.reflected = refl;
      pending.push_back(r);
    endfunction

    function void open_top_record(logic [15:0] t);
      logic [2:0] k;
      case (t)
        gdsp_pkg::T_BGNSTR: begin
          str_open = 1; push_event(gdsp_pkg::EV_BGNSTR); return;
        end
        gdsp_pkg::T_ENDSTR: begin
          if (str_open) begin
            str_open = 0; push_event(gdsp_pkg::EV_ENDSTR);
          end
          return;
        end
        gdsp_pkg::T_ENDLIB: begin
          push_event(gdsp_pkg::EV_ENDLIB); return;
        end
        gdsp_pkg::T_BOUNDARY: k = gdsp_pkg::K_BOUNDARY;
        gdsp_pkg::T_PATH:     k = gdsp_pkg::K_PATH;
        gdsp_pkg::T_SREF:     k = gdsp_pkg::K_SREF;
        gdsp_pkg::T_AREF:     k = gdsp_pkg::K_AREF;
        gdsp_pkg::T_TEXT:     k = gdsp_pkg::K_TEXT;
        gdsp_pkg::T_BOX:      k = gdsp_pkg::K_BOX;
        default: return;
      endcase
      if (!str_open) return;
      ctx = k; lay = '0; dt = '0; wid = '0; colrow = '0; refl = 0; origin = '0;
    endfunction

    function void open_element_record(logic [15:0] t, logic [15:0] ds);
      logic [15:0] u;
      u = '0;
      if (t == gdsp_pkg::T_ENDEL) begin
        push_held(gdsp_pkg::EV_ENDEL, ctx, 32'd0, 32'd0, 13'd0);
        ctx = gdsp_pkg::K_TOP;
        return;
      end
      case (t)
        gdsp_pkg::T_LAYER:
          if ((ctx == gdsp_pkg::K_BOUNDARY || ctx == gdsp_pkg::K_PATH ||
               ctx == gdsp_pkg::K_TEXT || ctx == gdsp_pkg::K_BOX) && ds >= 16'd2)
            u = 16'd2;
        gdsp_pkg::T_DATATYPE:
          if (ctx == gdsp_pkg::K_BOUNDARY && ds >= 16'd2) u = 16'd2;
        gdsp_pkg::T_WIDTH:
          if (ctx == gdsp_pkg::K_PATH && ds >= 16'd4) u = 16'd4;
        gdsp_pkg::T_STRANS:
          if (ctx == gdsp_pkg::K_SREF && ds >= 16'd2) u = 16'd2;
        gdsp_pkg::T_COLROW:
          if (ctx == gdsp_pkg::K_AREF && ds >= 16'd4) u = 16'd4;
        gdsp_pkg::T_XY: begin
          if (ctx == gdsp_pkg::K_BOUNDARY || ctx == gdsp_pkg::K_PATH ||
              ctx == gdsp_pkg::K_BOX)
            u = ds & ~16'd7;
          else if (ctx == gdsp_pkg::K_SREF || ctx == gdsp_pkg::K_TEXT)
            u = (ds >= 16'd8) ? 16'd8 : 16'd0;
          else if (ctx == gdsp_pkg::K_AREF)
            u = (ds >= 16'd24) ? 16'd24 : 16'd0;
        end
        default: ;
      endcase
      use_left = u;
    endfunction

    function void payload(logic [7:0] b);
      logic [31:0] x, y;
      logic [12:0] idx;
      pay_left--;
      if (use_left == 0) return;
      use_left--;
      fshift = {fshift[55:0], b};
      if (rec_type == gdsp_pkg::T_XY) begin
        if (use_left[2:0] != 0) return;
        x = fshift[63:32]; y = fshift[31:0];
        idx = pcount; pcount++;
        if (ctx == gdsp_pkg::K_AREF) begin
          if (idx == 0) origin = fshift;
          else begin
            x = x - origin[63:32]; y = y - origin[31:0];
          end
        end
        push_held(gdsp_pkg::EV_POINT, ctx, x, y, idx);
        return;
      end
      if (use_left != 0) return;
      case (rec_type)
        gdsp_pkg::T_LAYER:    lay = fshift[15:0];
        gdsp_pkg::T_DATATYPE: dt = fshift[15:0];
        gdsp_pkg::T_WIDTH:    wid = fshift[31:0];
        gdsp_pkg::T_COLROW:   colrow = fshift[31:0];
        gdsp_pkg::T_STRANS:   refl = fshift[15];
        default: ;
      endcase
    endfunction

    // Notes one accepted byte transfer.
    function void note_byte(logic [7:0] b);
      logic [15:0] len;
      if (skip_next) begin
        skip_next = 0; return;
      end
      if (pay_left != 0) begin
        payload(b); return;
      end
      hdr = {hdr[23:0], b};
      hdr_cnt++;
      if (hdr_cnt < 4) return;
      hdr_cnt = 0;
      len = hdr[31:16];
      if (len < 16'd4 || len > max_len) begin
        skip_next = 1; push_event(gdsp_pkg::EV_RESYNC); return;
      end
      pay_left = len - 16'd4; rec_type = hdr[15:0];
      use_left = '0; pcount = '0; fshift = '0;
      if (ctx == gdsp_pkg::K_TOP) open_top_record(hdr[15:0]);
      else open_element_record(hdr[15:0], len - 16'd4);
    endfunction

    // Checks one result transfer against the oldest expectation.
    function void check_result(gdsp_pkg::result_t got);
      gdsp_pkg::result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result event_res=%0d", got.event_res);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.event_res != e.event_res) begin
        $error("event_res exp %0d got %0d", e.event_res, got.event_res); errors++;
      end
      if (got.element_kind != e.element_kind) begin
        $error("element_kind exp %0d got %0d", e.element_kind, got.element_kind);
        errors++;
      end
      if (got.layer_number != e.layer_number) begin
        $error("layer_number exp %h got %h", e.layer_number, got.layer_number);
        errors++;
      end
      if (got.data_type != e.data_type) begin
        $error("data_type exp %h got %h", e.data_type, got.data_type); errors++;
      end
      if (got.path_width != e.path_width) begin
        $error("path_width exp %h got %h", e.path_width, got.path_width); errors++;
      end
      if (got.coord_x != e.coord_x) begin
        $error("coord_x exp %h got %h", e.coord_x, got.coord_x); errors++;
      end
      if (got.coord_y != e.coord_y) begin
        $error("coord_y exp %h got %h", e.coord_y, got.coord_y); errors++;
      end
      if (got.point_index != e.point_index) begin
        $error("point_index exp %0d got %0d", e.point_index, got.point_index);
        errors++;
      end
      if (got.array_columns != e.array_columns) begin
        $error("array_columns exp %0d got %0d", e.array_columns, got.array_columns);
        errors++;
      end
      if (got.array_rows != e.array_rows) begin
        $error("array_rows exp %0d got %0d", e.array_rows, got.array_rows); errors++;
      end
      if (got.reflected != e.reflected) begin
        $error("reflected exp %0d got %0d", e.reflected, got.reflected); errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid, out_stall;
  logic [2:0]  out_event_res, out_element_kind;
  logic signed [15:0] out_layer_number, out_data_type;
  logic signed [31:0] out_path_width, out_coord_x, out_coord_y;
  logic [12:0] out_point_index;
  logic [15:0] out_array_columns, out_array_rows;
  logic        out_reflected;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  gdsii_record_stream_parser dut (.*);

  gds_scoreboard sb;
  logic [7:0] stream_q[$];     // bytes waiting to be sent
  int   bytes_sent;
  bit   stream_done;
  bit   hold_off_req;          // asks the receiver for a long stall

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sender: bursts of random length with random gaps.
  initial begin
    int burst, gap;
    in_valid <= 0; in_data_byte <= 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      burst = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      while (burst > 0) begin
        if (stream_q.size() == 0) begin
          in_valid <= 0;
          @(posedge clk);
        end else begin
          in_valid <= 1; in_data_byte <= stream_q[0];
          @(posedge clk);
          if (!in_stall) begin
            // transfer completed at this edge
            sb.note_byte(stream_q.pop_front());
            bytes_sent++;
            burst--;
          end
        end
      end
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Receiver: own stall pattern, plus a long hold-off on request.
  initial begin
    int mode, hold;
    out_stall <= 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result('{out_event_res, out_element_kind,
          out_layer_number, out_data_type, out_path_width, out_coord_x, out_coord_y,
          out_point_index, out_array_columns, out_array_rows, out_reflected});
      if (hold_off_req) begin
        hold_off_req = 0; hold = 300;
      end
      if (hold > 0) begin
        hold--; out_stall <= 1;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  task automatic cfg_write(logic [15:0] val);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1; cfg_paddr <= 0;
    cfg_pwdata <= {16'd0, val};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.max_len = val;
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // Waits for all queued bytes to be taken and every result to arrive.
  task automatic drain();
    while (stream_q.size() != 0) @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put16(logic [15:0] v);
    stream_q.push_back(v[15:8]); stream_q.push_back(v[7:0]);
  endtask

  task automatic put32(logic [31:0] v);
    put16(v[31:16]); put16(v[15:0]);
  endtask

  task automatic put_rec(logic [15:0] t, int nbytes);
    put16(16'(nbytes + 4)); put16(t);
    repeat (nbytes) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] pick_kind();
    case ($urandom_range(0, 5))
      0: return gdsp_pkg::T_BOUNDARY;
      1: return gdsp_pkg::T_PATH;
      2: return gdsp_pkg::T_SREF;
      3: return gdsp_pkg::T_AREF;
      4: return gdsp_pkg::T_TEXT;
      default: return gdsp_pkg::T_BOX;
    endcase
  endfunction

  // One element with random content, mostly well-formed.
  task automatic put_element();
    logic [15:0] k;
    int n;
    k = pick_kind();
    put_rec(k, 0);
    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 6))
        0: put_rec(gdsp_pkg::T_LAYER,
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : 2);
        1: put_rec(gdsp_pkg::T_DATATYPE, 2);
        2: put_rec(gdsp_pkg::T_WIDTH,
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 6) : 4);
        3: put_rec(gdsp_pkg::T_STRANS, 2);
        4: put_rec(gdsp_pkg::T_COLROW, 4);
        5: put_rec(gdsp_pkg::T_XY, $urandom_range(0, 3) == 0 ? $urandom_range(0, 30)
                                                   : 8 * $urandom_range(1, 4));
        default: put_rec(gdsp_pkg::T_BGNSTR, $urandom_range(0, 3));
      endcase
    end
    if (k == gdsp_pkg::T_AREF || $urandom_range(0, 2) == 0) put_rec(gdsp_pkg::T_XY, 24);
    put_rec(gdsp_pkg::T_ENDEL, 0);
  endtask

  task automatic put_noise();
    case ($urandom_range(0, 3))
      0: repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom_range(0, 255)));
      1: begin
        put16(16'($urandom_range(0, 3))); put16(16'($urandom()));
      end
      2: put_rec(gdsp_pkg::T_ENDSTR, 0);
      default: put_rec(16'($urandom()), $urandom_range(0, 6));
    endcase
  endtask

  task automatic random_phase(int nbytes, int max_rec);
    int target;
    target = bytes_sent + nbytes;
    while (bytes_sent < target) begin
      case ($urandom_range(0, 9))
        0: put_rec(gdsp_pkg::T_BGNSTR, $urandom_range(0, 2) * 2);
        1: put_rec(gdsp_pkg::T_ENDSTR, 0);
        2: put_noise();
        3: put_rec(gdsp_pkg::T_ENDLIB, 0);
        default: put_element();
      endcase
      if (max_rec < 40 && $urandom_range(0, 1) == 0) put_noise();
      while (stream_q.size() > 64) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    sb = new();
    bytes_sent = 0; hold_off_req = 0;
    rst_n <= 0;
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0; cfg_paddr <= 0; cfg_pwdata <= 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: elements at top level, full-range fields, bad lengths.
    put_rec(gdsp_pkg::T_BOUNDARY, 0);    // element without structure: ignored
    put_rec(gdsp_pkg::T_ENDEL, 0);       // endel at top level
    put_rec(gdsp_pkg::T_ENDSTR, 0);      // endstr with no open structure
    put_rec(gdsp_pkg::T_BGNSTR, 0);
    put_rec(gdsp_pkg::T_AREF, 0);
    put_rec(gdsp_pkg::T_COLROW, 4);
    put16(16'd28); put16(gdsp_pkg::T_XY);
    put32(32'h7FFF_FFFF); put32(32'h8000_0000);
    put32(32'h8000_0000); put32(32'h7FFF_FFFF); put32(32'hFFFF_FFFF); put32(32'd0);
    put_rec(gdsp_pkg::T_ENDSTR, 0);      // skipped inside element
    put_rec(gdsp_pkg::T_ENDEL, 0);
    put_rec(gdsp_pkg::T_SREF, 0);
    put16(16'd6); put16(gdsp_pkg::T_STRANS); put16(16'h8000);
    put_rec(gdsp_pkg::T_XY, 4);          // short xy
    put_rec(gdsp_pkg::T_XY, 9);
    put_rec(gdsp_pkg::T_ENDEL, 0);
    put16(16'd2); put16(gdsp_pkg::T_BOX);  // bad length, then skipped byte
    stream_q.push_back(8'hFF);
    put16(16'hFFFF); put16(gdsp_pkg::T_BOX);
    stream_q.push_back(8'h00);
    put_rec(gdsp_pkg::T_ENDSTR, 0);
    put_rec(gdsp_pkg::T_ENDLIB, 0);
    drain();

    random_phase(450, 65532);

    // Receiver holds off while bytes keep coming.
    hold_off_req = 1;
    random_phase(200, 65532);

    cfg_write(16'd3);                    // every record resyncs
    random_phase(100, 3);
    cfg_write(16'd20);                   // long xy and arefs resync
    random_phase(250, 20);
    cfg_write(16'hFFFF);
    random_phase(250, 65535);
    cfg_write(16'd4);
    random_phase(80, 4);
    cfg_write(16'd65532);
    random_phase(120, 65532);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: filelist.f
design/gdsp_pkg.sv
design/gdsp_front.sv
design/gdsp_queue.sv
design/gdsii_record_stream_parser.sv
test/tb_gdsii_record_stream_parser.sv
